// File: src/i2ctrm_pkg.sv
// Package for the I2C target register map: item types, event codes and constants.
// No dependencies; every other file of the block imports it.
`default_nettype none

package i2ctrm_pkg;

    // Bus event codes carried in the mode field of an input item.
    localparam logic [2:0] EV_TXRDY   = 3'd0;
    localparam logic [2:0] EV_RXBYTE  = 3'd1;
    localparam logic [2:0] EV_MATCH   = 3'd2;
    localparam logic [2:0] EV_NACK    = 3'd3;
    localparam logic [2:0] EV_STOP    = 3'd4;
    localparam logic [2:0] EV_TIMEOUT = 3'd5;
    localparam logic [2:0] EV_ERROR   = 3'd6;

    // Register numbers of the map.
    localparam logic [7:0] REG_TICK       = 8'd0;
    localparam logic [7:0] REG_MSTATE     = 8'd1;
    localparam logic [7:0] REG_MERROR     = 8'd2;
    localparam logic [7:0] REG_SPEED      = 8'd3;
    localparam logic [7:0] REG_CURRENT    = 8'd4;
    localparam logic [7:0] REG_VOLTAGE    = 8'd5;
    localparam logic [7:0] REG_TEMP       = 8'd6;
    localparam logic [7:0] REG_OL_TARGET  = 8'd7;

    // Motor command codes.
    localparam logic [1:0] MCMD_NONE  = 2'd0;
    localparam logic [1:0] MCMD_START = 2'd1;
    localparam logic [1:0] MCMD_STOP  = 2'd2;

    // Miscellaneous constants.
    localparam logic [7:0]  NOT_KNOWN_BYTE    = 8'hCA;
    localparam logic [7:0]  CMD_START_BYTE    = 8'd1;
    localparam logic [15:0] START_SPEED_RESET = 16'd2000;
    localparam int          STORE_DEPTH       = 4;

    // Four-byte send store, entry 0 goes out first.
    typedef logic [STORE_DEPTH-1:0][7:0] t_store;

    // One input item: a bus event plus the snapshot of served values.
    typedef struct packed {
        logic [2:0]         mode;
        logic [7:0]         data_in;
        logic [31:0]        tick_count;
        logic [7:0]         motor_state;
        logic [7:0]         motor_error;
        logic signed [31:0] speed_rpm;
        logic signed [31:0] phase_current;
        logic signed [31:0] bus_voltage;
        logic signed [31:0] temperature;
        logic [15:0]        open_loop_target;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        size_valid;
        logic [2:0]  transfer_size;
        logic [1:0]  motor_command;
        logic [15:0] motor_speed;
    } t_out_item;

endpackage

`default_nettype wire

// File: src/i2ctrm_if.sv
// Valid/ready channel interfaces for input items and result items.
// Depends on i2ctrm_pkg for the payload types.
`default_nettype none

interface i2ctrm_in_if;
    import i2ctrm_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface i2ctrm_out_if;
    import i2ctrm_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: src/i2ctrm_load.sv
// Read-reply loader: packs the selected register big-endian into the send store.
// Depends on i2ctrm_pkg.
`default_nettype none

module i2ctrm_load (
    input  wire logic [7:0]          i_register_select,
    input  wire i2ctrm_pkg::t_in_item i_item,
    input  wire i2ctrm_pkg::t_store  i_store,
    output i2ctrm_pkg::t_store       o_store,
    output logic [2:0]               o_count
);
    import i2ctrm_pkg::*;

    // Bytes past the loaded count keep what an earlier load left.
    // Entry 0 goes out first, so it takes the most significant byte.
    always_comb begin
        o_store = i_store;
        o_count = 3'd1;
        case (i_register_select)
            REG_TICK: begin
                o_store = {i_item.tick_count[7:0], i_item.tick_count[15:8],
                           i_item.tick_count[23:16], i_item.tick_count[31:24]};
                o_count = 3'd4;
            end
            REG_MSTATE: begin
                o_store[0] = i_item.motor_state;
            end
            REG_MERROR: begin
                o_store[0] = i_item.motor_error;
            end
            REG_SPEED: begin
                o_store = {i_item.speed_rpm[7:0], i_item.speed_rpm[15:8],
                           i_item.speed_rpm[23:16], i_item.speed_rpm[31:24]};
                o_count = 3'd4;
            end
            REG_CURRENT: begin
                o_store = {i_item.phase_current[7:0], i_item.phase_current[15:8],
                           i_item.phase_current[23:16], i_item.phase_current[31:24]};
                o_count = 3'd4;
            end
            REG_VOLTAGE: begin
                o_store = {i_item.bus_voltage[7:0], i_item.bus_voltage[15:8],
                           i_item.bus_voltage[23:16], i_item.bus_voltage[31:24]};
                o_count = 3'd4;
            end
            REG_TEMP: begin
                o_store = {i_item.temperature[7:0], i_item.temperature[15:8],
                           i_item.temperature[23:16], i_item.temperature[31:24]};
                o_count = 3'd4;
            end
            REG_OL_TARGET: begin
                o_store[0] = i_item.open_loop_target[15:8];
                o_store[1] = i_item.open_loop_target[7:0];
                o_count    = 3'd2;
            end
            default: begin
                // Unknown register answers with a single marker byte.
                o_store[0] = NOT_KNOWN_BYTE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: src/i2c_target_register_map.sv
// Top level of the I2C target register map: event decoding, state and result register.
// Depends on i2ctrm_pkg, i2ctrm_in_if / i2ctrm_out_if and i2ctrm_load.
//
//   Channel   Direction  Handshake        Carries
//   i_in      in         valid/ready      one bus event with register snapshots
//   o_out     out        valid/ready      one result per event
//   i_cfg     in         write enable     start_speed (16 bit)
//
// Each event is decoded in the cycle it is accepted; its result appears in the
// output register on the next cycle, and one event can be taken every cycle.
// The only stall is the output register: a new event is accepted while the
// result is empty or being taken. Reset is synchronous and returns the block
// to idle with start_speed 2000 and an all-zero send store.
`default_nettype none

module i2c_target_register_map (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    i2ctrm_in_if.sink        i_in,
    i2ctrm_out_if.source     o_out
);
    import i2ctrm_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SELECT,
        PH_RECEIVE,
        PH_SEND
    } t_phase;

    t_phase      r_phase, n_phase, w_phase_mid;
    logic [7:0]  r_select, n_select;
    logic [7:0]  r_rx_count, n_rx_count;
    logic [7:0]  r_cmd_byte, n_cmd_byte;
    logic [7:0]  r_send_pos, n_send_pos;
    t_store      r_store, n_store;
    logic [15:0] r_start_speed;
    logic        r_out_valid;
    t_out_item   r_out, n_out;

    t_store      w_load_store;
    logic [2:0]  w_load_count;
    logic        w_in_fire;
    t_in_item    w_item;

    assign w_item    = i_in.payload;
    assign i_in.ready = ~r_out_valid | o_out.ready;
    assign w_in_fire = i_in.valid & i_in.ready;

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    // Read replies are packed from the snapshot fields.
    i2ctrm_load u_load (
        .i_register_select (r_select),
        .i_item            (w_item),
        .i_store           (r_store),
        .o_store           (w_load_store),
        .o_count           (w_load_count)
    );

    // Event decoding: address match and abort events first, then the phase action.
    always_comb begin
        n_phase    = r_phase;
        n_select   = r_select;
        n_rx_count = r_rx_count;
        n_cmd_byte = r_cmd_byte;
        n_send_pos = r_send_pos;
        n_store    = r_store;
        n_out      = '0;
        w_phase_mid = r_phase;

        if (w_item.mode == EV_MATCH) begin
            if (w_item.data_in == 8'd0) begin
                n_rx_count  = 8'd0;
                w_phase_mid = PH_SELECT;
            end else begin
                n_store             = w_load_store;
                n_out.size_valid    = 1'b1;
                n_out.transfer_size = w_load_count;
                n_out.tx_valid      = 1'b1;
                n_out.tx_byte       = w_load_store[0];
                n_send_pos          = 8'd1;
                w_phase_mid         = PH_SEND;
            end
        end else if (w_item.mode == EV_TIMEOUT || w_item.mode == EV_ERROR) begin
            w_phase_mid = PH_IDLE;
        end
        n_phase = w_phase_mid;

        case (w_phase_mid)
            PH_IDLE: begin
                n_out.size_valid    = 1'b1;
                n_out.transfer_size = 3'd0;
            end
            PH_SELECT: begin
                if (w_item.mode == EV_RXBYTE) begin
                    n_select = w_item.data_in;
                    n_phase  = PH_RECEIVE;
                end
            end
            PH_RECEIVE: begin
                if (w_item.mode == EV_RXBYTE) begin
                    if (r_rx_count == 8'd0) begin
                        n_cmd_byte = w_item.data_in;
                    end
                    n_rx_count = r_rx_count + 8'd1;
                end
                // Stop on register 0 issues the motor command.
                if (w_item.mode == EV_STOP && r_select == REG_TICK) begin
                    if (r_cmd_byte == CMD_START_BYTE) begin
                        n_out.motor_command = MCMD_START;
                        n_out.motor_speed   = r_start_speed;
                    end else begin
                        n_out.motor_command = MCMD_STOP;
                    end
                end
            end
            PH_SEND: begin
                if (w_item.mode == EV_TXRDY) begin
                    n_out.tx_valid = 1'b1;
                    n_out.tx_byte  = (r_send_pos < 8'(STORE_DEPTH))
                                     ? r_store[r_send_pos[1:0]] : 8'h00;
                    n_send_pos     = r_send_pos + 8'd1;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // State, configuration register and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_select      <= 8'd0;
            r_rx_count    <= 8'd0;
            r_cmd_byte    <= 8'd0;
            r_send_pos    <= 8'd0;
            r_store       <= '0;
            r_start_speed <= START_SPEED_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_start_speed <= i_cfg_wdata;
            end
            if (w_in_fire) begin
                r_phase    <= n_phase;
                r_select   <= n_select;
                r_rx_count <= n_rx_count;
                r_cmd_byte <= n_cmd_byte;
                r_send_pos <= n_send_pos;
                r_store    <= n_store;
                r_out      <= n_out;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// File: sim/i2ctrm_checker.sv
// Result checker for the I2C target register map: predicts each result item and compares.
// Depends on i2ctrm_pkg and the channel interfaces i2ctrm_in_if and i2ctrm_out_if.

module i2ctrm_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    i2ctrm_in_if             i_in_mon,
    i2ctrm_out_if            i_out_mon,
    output int               o_pending,
    output int               o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import i2ctrm_pkg::*;

    localparam logic [7:0] DIR_WRITE    = 8'd0;
    localparam int         REPORT_LIMIT = 10;

    typedef enum logic [1:0] {
        BUS_IDLE,
        BUS_SELECT,
        BUS_RECEIVE,
        BUS_SEND
    } t_bus_phase;

    // Predicted state of the register map.
    logic [15:0] start_speed;
    t_bus_phase  bus_phase;
    logic [7:0]  reg_sel;
    logic [7:0]  rx_count;
    logic [7:0]  cmd_byte;
    logic [7:0]  send_pos;
    t_store      reply;

    // Results owed by the block, oldest first.
    t_out_item   results_due[$];
    int          reported;

    // Loads the selected register big-endian into the reply store and returns its length.
    function automatic logic [2:0] load_reply(input t_in_item it);
        logic [31:0] word;
        int          nbytes;
        case (reg_sel)
            REG_TICK:      begin word = it.tick_count;              nbytes = 4; end
            REG_MSTATE:    begin word = {24'd0, it.motor_state};    nbytes = 1; end
            REG_MERROR:    begin word = {24'd0, it.motor_error};    nbytes = 1; end
            REG_SPEED:     begin word = it.speed_rpm;               nbytes = 4; end
            REG_CURRENT:   begin word = it.phase_current;           nbytes = 4; end
            REG_VOLTAGE:   begin word = it.bus_voltage;             nbytes = 4; end
            REG_TEMP:      begin word = it.temperature;             nbytes = 4; end
            REG_OL_TARGET: begin word = {16'd0, it.open_loop_target}; nbytes = 2; end
            default:       begin word = {24'd0, NOT_KNOWN_BYTE};    nbytes = 1; end
        endcase
        // Bytes past the loaded length keep whatever an earlier load left there.
        for (int k = 0; k < nbytes; k++) begin
            reply[k] = word[8*(nbytes-1-k) +: 8];
        end
        return 3'(nbytes);
    endfunction

    // Advances the predicted state by one bus event and returns the result it causes.
    function automatic t_out_item predict_event(input t_in_item it);
        t_out_item r;
        r = '0;
        if (it.mode == EV_MATCH) begin
            if (it.data_in == DIR_WRITE) begin
                rx_count  = 8'd0;
                bus_phase = BUS_SELECT;
            end else begin
                r.size_valid    = 1'b1;
                r.transfer_size = load_reply(it);
                r.tx_valid      = 1'b1;
                r.tx_byte       = reply[0];
                send_pos        = 8'd1;
                bus_phase       = BUS_SEND;
            end
        end else if (it.mode == EV_TIMEOUT || it.mode == EV_ERROR) begin
            bus_phase = BUS_IDLE;
        end

        case (bus_phase)
            BUS_IDLE: begin
                r.size_valid    = 1'b1;
                r.transfer_size = 3'd0;
            end
            BUS_SELECT: begin
                if (it.mode == EV_RXBYTE) begin
                    reg_sel   = it.data_in;
                    bus_phase = BUS_RECEIVE;
                end
            end
            BUS_RECEIVE: begin
                // Only the first data byte is kept; the count wraps and may replace it.
                if (it.mode == EV_RXBYTE) begin
                    if (rx_count == 8'd0) begin
                        cmd_byte = it.data_in;
                    end
                    rx_count = rx_count + 8'd1;
                end
                if (it.mode == EV_STOP && reg_sel == REG_TICK) begin
                    if (cmd_byte == CMD_START_BYTE) begin
                        r.motor_command = MCMD_START;
                        r.motor_speed   = start_speed;
                    end else begin
                        r.motor_command = MCMD_STOP;
                    end
                end
            end
            default: begin
                // Positions past the store send zero; the position wraps at 8 bits.
                if (it.mode == EV_TXRDY) begin
                    r.tx_valid = 1'b1;
                    r.tx_byte  = (send_pos < 8'd4) ? reply[send_pos[1:0]] : 8'h00;
                    send_pos   = send_pos + 8'd1;
                end
            end
        endcase
        return r;
    endfunction

    // Watch both channels and the configuration port at every rising edge.
    always @(posedge i_clk) begin
        t_out_item got;
        t_out_item want;
        if (!i_rst_n) begin
            start_speed = START_SPEED_RESET;
            bus_phase   = BUS_IDLE;
            reg_sel     = 8'd0;
            rx_count    = 8'd0;
            cmd_byte    = 8'd0;
            send_pos    = 8'd0;
            reply       = '0;
            results_due.delete();
            reported     = 0;
            o_fail_count = 0;
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                got = i_out_mon.payload;
                if (results_due.size() == 0) begin
                    o_fail_count++;
                    if (reported < REPORT_LIMIT) begin
                        $display("%0t: result item with none outstanding: %h", $time, got);
                        reported++;
                    end
                end else begin
                    want = results_due.pop_front();
                    if (got.tx_valid !== want.tx_valid || got.tx_byte !== want.tx_byte ||
                        got.size_valid !== want.size_valid ||
                        got.transfer_size !== want.transfer_size ||
                        got.motor_command !== want.motor_command ||
                        got.motor_speed !== want.motor_speed) begin
                        o_fail_count++;
                        if (reported < REPORT_LIMIT) begin
                            $display("%0t: mismatch, expected tx %b/%h size %b/%0d motor %0d/%0d",
                                     $time, want.tx_valid, want.tx_byte, want.size_valid,
                                     want.transfer_size, want.motor_command, want.motor_speed);
                            $display("%0t:           actual   tx %b/%h size %b/%0d motor %0d/%0d",
                                     $time, got.tx_valid, got.tx_byte, got.size_valid,
                                     got.transfer_size, got.motor_command, got.motor_speed);
                            reported++;
                        end
                    end
                end
            end
            // An item taken at the same edge as a write still sees the old speed.
            if (i_in_mon.valid && i_in_mon.ready) begin
                results_due.push_back(predict_event(i_in_mon.payload));
            end
            if (i_cfg_we) begin
                start_speed = i_cfg_wdata;
            end
        end
        o_pending <= results_due.size();
    end

endmodule

// File: sim/i2c_target_register_map_tb.sv
// Testbench top for the I2C target register map: clock, reset, stimulus and verdict.
// Depends on i2ctrm_pkg, the channel interfaces, the block itself and i2ctrm_checker.

module i2c_target_register_map_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2ctrm_pkg::*;

    localparam logic [2:0] EV_UNUSED      = 3'd7;
    localparam logic [7:0] DIR_WRITE      = 8'd0;
    localparam logic [7:0] DIR_READ       = 8'd1;
    localparam int         RANDOM_EVENTS  = 1100;
    localparam int         LONG_HOLD      = 300;
    localparam int         WATCHDOG_LIMIT = 3000;

    // Receiver stall patterns.
    localparam int RX_ALWAYS       = 0;
    localparam int RX_COIN         = 1;
    localparam int RX_ONE_IN_THREE = 2;
    localparam int RX_MOSTLY       = 3;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    int          expected_left;
    int          fail_count;
    int          events_sent;
    int          burst_left;
    int          hold_requests;
    int          holds_done;
    int          idle_cycles;

    i2ctrm_in_if  in_ch ();
    i2ctrm_out_if out_ch ();

    i2c_target_register_map dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    i2ctrm_checker chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_pending    (expected_left),
        .o_fail_count (fail_count)
    );

    // Free-running clock, 8 ns period.
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Snapshot values lean on the boundaries now and then.
    function automatic logic [31:0] snapshot_word();
        case ($urandom_range(0, 11))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in_item make_event(input logic [2:0] mode, input logic [7:0] data);
        t_in_item it;
        it.mode             = mode;
        it.data_in          = data;
        it.tick_count       = snapshot_word();
        it.motor_state      = 8'(snapshot_word());
        it.motor_error      = 8'(snapshot_word());
        it.speed_rpm        = snapshot_word();
        it.phase_current    = snapshot_word();
        it.bus_voltage      = snapshot_word();
        it.temperature      = snapshot_word();
        it.open_loop_target = 16'(snapshot_word());
        return it;
    endfunction

    // Mostly the defined registers, sometimes any select value.
    function automatic logic [7:0] pick_register();
        if ($urandom_range(0, 99) < 75) begin
            return 8'($urandom_range(0, 8));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Offers one item in bursts with random gaps and waits until it is taken.
    task automatic offer(input t_in_item it);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_ch.valid   <= 1'b1;
        in_ch.payload <= it;
        do @(posedge clk); while (!in_ch.ready);
        events_sent++;
    endtask

    task automatic post(input logic [2:0] mode, input logic [7:0] data);
        offer(make_event(mode, data));
    endtask

    // Stops offering and waits until every result owed has been taken.
    task automatic drain();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (expected_left != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_start_speed(input logic [15:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Write transfer: select byte, data bytes biased toward the start command, then a close.
    task automatic write_transfer(input logic [7:0] sel, input int n_data);
        int pick;
        post(EV_MATCH, DIR_WRITE);
        post(EV_RXBYTE, sel);
        repeat (n_data) begin
            if ($urandom_range(0, 3) == 0) begin
                post(EV_RXBYTE, 8'($urandom));
            end else begin
                post(EV_RXBYTE, 8'($urandom_range(0, 1)));
            end
        end
        pick = $urandom_range(0, 19);
        if (pick < 17) begin
            post(EV_STOP, 8'($urandom));
        end else if (pick == 17) begin
            post(EV_TIMEOUT, 8'($urandom));
        end else if (pick == 18) begin
            post(EV_ERROR, 8'($urandom));
        end else begin
            post(EV_NACK, 8'($urandom));
        end
    endtask

    // Read transfer, optionally preceded by a register select without a stop.
    task automatic read_transfer(input bit select_first, input logic [7:0] sel, input int n_tx);
        int pick;
        if (select_first) begin
            post(EV_MATCH, DIR_WRITE);
            post(EV_RXBYTE, sel);
        end
        post(EV_MATCH, 8'($urandom_range(1, 255)));
        repeat (n_tx) post(EV_TXRDY, 8'($urandom));
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            post(EV_NACK, 8'($urandom));
            post(EV_STOP, 8'($urandom));
        end else if (pick < 8) begin
            post(EV_STOP, 8'($urandom));
        end else begin
            post(($urandom_range(0, 1) != 0) ? EV_TIMEOUT : EV_ERROR, 8'($urandom));
        end
    endtask

    // Receiver: changing stall patterns, plus a long hold-off whenever one is requested.
    initial begin : receiver
        int style;
        int style_left;
        int tick;
        out_ch.ready = 1'b0;
        style        = RX_ALWAYS;
        style_left   = 0;
        tick         = 0;
        forever begin
            @(posedge clk);
            if (holds_done != hold_requests) begin
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                holds_done++;
            end
            if (style_left == 0) begin
                style      = $urandom_range(RX_ALWAYS, RX_MOSTLY);
                style_left = $urandom_range(20, 150);
            end
            style_left--;
            tick++;
            case (style)
                RX_ALWAYS:       out_ch.ready <= 1'b1;
                RX_COIN:         out_ch.ready <= 1'($urandom_range(0, 1));
                RX_ONE_IN_THREE: out_ch.ready <= (tick % 3 == 0);
                default:         out_ch.ready <= ($urandom_range(0, 99) < 85);
            endcase
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge clk) begin
        if (!rst_n || cfg_we || (in_ch.valid && in_ch.ready) ||
            (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Reset, directed events, four random phases at different start speeds, verdict.
    initial begin : stimulus
        t_in_item it;
        int       chunk_end;
        int       pick;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = 16'd0;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        events_sent   = 0;
        burst_left    = 0;
        hold_requests = 0;
        holds_done    = 0;
        idle_cycles   = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Idle events, including nack and the unused mode, all report size zero.
        post(EV_TXRDY, 8'h00);
        post(EV_NACK, 8'hFF);
        post(EV_UNUSED, 8'h55);

        // Start at the reset speed, then a stop with no new command byte reuses the old one.
        post(EV_MATCH, DIR_WRITE);
        post(EV_RXBYTE, REG_TICK);
        post(EV_RXBYTE, CMD_START_BYTE);
        post(EV_STOP, 8'h00);
        post(EV_MATCH, DIR_WRITE);
        post(EV_RXBYTE, REG_TICK);
        post(EV_STOP, 8'hFF);

        // Any other command byte stops the motor; later bytes are only counted.
        post(EV_MATCH, DIR_WRITE);
        post(EV_RXBYTE, REG_TICK);
        post(EV_RXBYTE, 8'hFF);
        post(EV_RXBYTE, CMD_START_BYTE);
        post(EV_STOP, 8'h00);

        // Four-byte read of an all-ones tick, running past the end of the store.
        it = make_event(EV_MATCH, 8'hFF);
        it.tick_count = 32'hFFFF_FFFF;
        offer(it);
        repeat (4) post(EV_TXRDY, 8'h00);

        // Most negative speed, then an unknown register that keeps the old store tail.
        post(EV_MATCH, DIR_WRITE);
        post(EV_RXBYTE, REG_SPEED);
        it = make_event(EV_MATCH, DIR_READ);
        it.speed_rpm = 32'sh8000_0000;
        offer(it);
        post(EV_MATCH, DIR_WRITE);
        post(EV_RXBYTE, 8'hFF);
        post(EV_MATCH, 8'h80);
        post(EV_TXRDY, 8'hFF);

        // Timeout and error fall back to idle.
        post(EV_TIMEOUT, 8'h00);
        post(EV_TXRDY, 8'h00);
        post(EV_ERROR, 8'hFF);

        for (int chunk = 0; chunk < 4; chunk++) begin
            case (chunk)
                0:       write_start_speed(16'hFFFF);
                1:       write_start_speed(16'h0000);
                default: write_start_speed(16'($urandom));
            endcase
            chunk_end = events_sent + RANDOM_EVENTS / 4;
            // The receiver holds off while items keep coming, so the input stalls.
            if (chunk == 1 || chunk == 3) begin
                hold_requests++;
            end
            // Long transfers wrap the receive count and the send position.
            if (chunk == 1) begin
                write_transfer(REG_TICK, 260);
            end
            if (chunk == 2) begin
                read_transfer(1'b1, REG_TICK, 260);
            end
            while (events_sent < chunk_end) begin
                pick = $urandom_range(0, 99);
                if (pick < 40) begin
                    write_transfer(pick_register(), $urandom_range(0, 3));
                end else if (pick < 80) begin
                    read_transfer($urandom_range(0, 9) < 6, pick_register(),
                                  $urandom_range(0, 6));
                end else if (pick < 95) begin
                    post(3'($urandom_range(0, 7)), 8'($urandom));
                end else begin
                    post(EV_MATCH, 8'($urandom));
                    post(($urandom_range(0, 1) != 0) ? EV_TIMEOUT : EV_ERROR, 8'($urandom));
                end
            end
        end

        drain();
        repeat (4) @(posedge clk);
        if (fail_count == 0 && expected_left == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
